### rtl/pst_pkg.sv
`timescale 1ns / 1ps
package pst_pkg;
	localparam int MaxProc = 32;
	localparam int IdxW = $clog2(MaxProc);
	localparam int CntW = IdxW + 1;
	localparam int SumW = 40;

	typedef enum logic [3:0] {
		ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_SORT_WR_HI, ST_ACC, ST_DIV,
		ST_OUT_RD, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic sort_init;
		logic sort_rd;
		logic sort_wr;
		logic sort_wr_hi;
		logic sort_next;
		logic acc_init;
		logic acc_step;
		logic div_start;
		logic out_init;
		logic out_rd;
		logic out_next;
	} cmd_t;

	typedef struct packed {
		logic sort_done;
		logic acc_done;
		logic div_done;
		logic out_last;
		logic full;
	} status_t;
endpackage

### rtl/pst_ctrl.sv
`timescale 1ns / 1ps
module pst_ctrl
	import pst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    in_last,
	input  logic    out_fire,
	input  status_t sts,
	output cmd_t    cmd,
	output logic    s_ready,
	output logic    m_valid
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:       if (in_fire && in_last) state_d = ST_SORT_RD;
			ST_SORT_RD:    state_d = sts.sort_done ? ST_ACC : ST_SORT_CMP;
			ST_SORT_CMP:   state_d = ST_SORT_WR;
			ST_SORT_WR:    state_d = ST_SORT_WR_HI;
			ST_SORT_WR_HI: state_d = ST_SORT_RD;
			ST_ACC:        if (sts.acc_done) state_d = ST_DIV;
			ST_DIV:        if (sts.div_done) state_d = ST_OUT_RD;
			ST_OUT_RD:     state_d = ST_OUT;
			ST_OUT:        if (out_fire) state_d = sts.out_last ? ST_LOAD : ST_OUT_RD;
			default:       state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_ready = 1'b0;
		m_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_ready = 1'b1;
				cmd.load = in_fire;
				cmd.sort_init = in_fire && in_last;
			end
			ST_SORT_RD: begin
				cmd.sort_rd = !sts.sort_done;
				cmd.acc_init = sts.sort_done;
			end
			ST_SORT_WR: cmd.sort_wr = 1'b1;
			ST_SORT_WR_HI: begin
				cmd.sort_wr_hi = 1'b1;
				cmd.sort_next = 1'b1;
			end
			ST_ACC: begin
				cmd.acc_step = 1'b1;
				cmd.div_start = sts.acc_done;
			end
			ST_DIV: cmd.out_init = sts.div_done;
			ST_OUT_RD: cmd.out_rd = 1'b1;
			ST_OUT: begin
				m_valid = 1'b1;
				cmd.out_rd = 1'b1;
				cmd.out_next = out_fire;
				cmd.clr = out_fire && sts.out_last;
			end
			default: ;
		endcase
	end
endmodule

### rtl/pst_div.sv
`timescale 1ns / 1ps
module pst_div
	import pst_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SumW-1:0] num_a,
	input  logic [SumW-1:0] num_b,
	input  logic [CntW-1:0] den,
	output logic [28:0]     quo_a,
	output logic [28:0]     quo_b,
	output logic            done
);
	// restoring division, one quotient bit per cycle for both sums
	logic [SumW-1:0] qa_q, qb_q;
	logic [CntW:0]   ra_q, rb_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic [CntW:0]   ta, tb;

	assign ta = {ra_q[CntW-1:0], qa_q[SumW-1]};
	assign tb = {rb_q[CntW-1:0], qb_q[SumW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(SumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qa_q <= num_a;
			qb_q <= num_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			if (ta >= {1'b0, den}) begin
				ra_q <= ta - {1'b0, den};
				qa_q <= {qa_q[SumW-2:0], 1'b1};
			end else begin
				ra_q <= ta;
				qa_q <= {qa_q[SumW-2:0], 1'b0};
			end
			if (tb >= {1'b0, den}) begin
				rb_q <= tb - {1'b0, den};
				qb_q <= {qb_q[SumW-2:0], 1'b1};
			end else begin
				rb_q <= tb;
				qb_q <= {qb_q[SumW-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q && !start;
	assign quo_a = qa_q[28:0];
	assign quo_b = qb_q[28:0];
endmodule

### rtl/pst_dp.sv
`timescale 1ns / 1ps
module pst_dp
	import pst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [15:0] burst_in,
	input  logic [7:0]  prio_in,
	output status_t     sts,
	output logic [5:0]  number,
	output logic [7:0]  prio_o,
	output logic [15:0] burst_o,
	output logic [20:0] wait_o,
	output logic [20:0] tat_o,
	output logic [28:0] avg_w,
	output logic [28:0] avg_t,
	output logic        ovf,
	output logic        last_o
);
	// one record per entry: {id, prio, burst}; single write / two read ports
	localparam int RecW = IdxW + 8 + 16;
	logic [RecW-1:0] mem [MaxProc];
	logic [RecW-1:0] rd_i_q, rd_k_q;

	logic [CntW-1:0] cnt_q;
	logic            drop_q;
	logic [IdxW-1:0] i_q, k_q;
	logic [CntW-1:0] p_q;
	logic            swap_q;
	logic [20:0]     wt_q;
	logic [SumW-1:0] sw_q, st_q;
	logic [IdxW-1:0] ra, rb;
	logic            we;
	logic [IdxW-1:0] wa;
	logic [RecW-1:0] wd;
	logic [20:0]     wt_next;
	logic            acc_go;
	logic            acc_v_q;

	assign acc_go = cmd.acc_step && (p_q != cnt_q);

	assign sts.full = (cnt_q == CntW'(MaxProc));
	assign sts.sort_done = ({1'b0, i_q} + CntW'(1) >= cnt_q);
	assign sts.acc_done = (p_q == cnt_q) && !acc_v_q;
	assign sts.out_last = (p_q + CntW'(1) == cnt_q);

	always_comb begin
		ra = i_q;
		rb = k_q;
		we = 1'b0;
		wa = cnt_q[IdxW-1:0];
		wd = {cnt_q[IdxW-1:0], prio_in, burst_in};
		if (cmd.load && !sts.full) we = 1'b1;
		if (cmd.acc_step || cmd.out_rd) ra = p_q[IdxW-1:0];
		if (cmd.sort_wr && swap_q) begin
			we = 1'b1;
			wa = i_q;
			wd = rd_k_q;
		end
		if (cmd.sort_wr_hi && swap_q) begin
			we = 1'b1;
			wa = k_q;
			wd = rd_i_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_i_q <= mem[ra];
		rd_k_q <= mem[rb];
	end

	assign wt_next = wt_q + 21'(rd_i_q[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			k_q <= '0;
			p_q <= '0;
			swap_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (sts.full) drop_q <= 1'b1;
				else cnt_q <= cnt_q + CntW'(1);
			end
			if (cmd.sort_init) begin
				i_q <= '0;
				k_q <= IdxW'(1);
			end
			if (cmd.sort_rd) swap_q <= 1'b0;
			else if (!cmd.sort_wr && !cmd.sort_wr_hi)
				swap_q <= rd_i_q[23:16] > rd_k_q[23:16];
			// advance k over the later positions, then i
			if (cmd.sort_next) begin
				if ({1'b0, k_q} + CntW'(1) >= cnt_q) begin
					i_q <= i_q + IdxW'(1);
					k_q <= i_q + IdxW'(2);
				end else k_q <= k_q + IdxW'(1);
			end
			if (cmd.acc_init || cmd.out_init) p_q <= '0;
			if (acc_go) p_q <= p_q + CntW'(1);
			if (cmd.out_next) p_q <= p_q + CntW'(1);
			if (cmd.clr) begin
				cnt_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	// accumulate the waiting sums; read data arrives in the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_v_q <= 1'b0;
		else acc_v_q <= acc_go;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_init || cmd.out_init) wt_q <= '0;
		if (cmd.acc_init) begin
			sw_q <= '0;
			st_q <= '0;
		end
		if (acc_v_q) begin
			sw_q <= sw_q + SumW'(wt_q);
			st_q <= st_q + SumW'(wt_next);
			wt_q <= wt_next;
		end
		if (cmd.out_next) wt_q <= wt_next;
	end

	logic div_done;
	pst_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num_a ({sw_q[SumW-9:0], 8'd0}),
		.num_b ({st_q[SumW-9:0], 8'd0}),
		.den   (cnt_q),
		.quo_a (avg_w),
		.quo_b (avg_t),
		.done  (div_done)
	);
	assign sts.div_done = div_done && !acc_v_q;

	assign number = 6'({1'b0, rd_i_q[RecW-1:24]} + 6'd1);
	assign prio_o = rd_i_q[23:16];
	assign burst_o = rd_i_q[15:0];
	assign wait_o = wt_q;
	assign tat_o = wt_next;
	assign ovf = drop_q;
	assign last_o = sts.out_last;
endmodule

### rtl/priority_schedule_timing.sv
`timescale 1ns / 1ps
// Non-preemptive priority scheduler. Load up to 32 processes, one request per
// cycle (burst, priority); the request with tlast starts scheduling. Requests
// past capacity are dropped and reported through the overflow flag. The set
// is sorted by an in-place exchange sort over a two-read-port record memory,
// each compare passing read, compare, write-low and write-high states, then
// summed, then both averages are divided by one restoring divider working on
// both sums in parallel, then results are streamed. Loading waits until the
// final result of the previous schedule is taken.
module priority_schedule_timing
	import pst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,  // burst_time[15:0], priority_level[23:16]
	input  logic         s_tlast,  // last_process
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // process_number, priority_out, burst_out,
	                               // waiting_time, turnaround_time, avg_wait_q8,
	                               // avg_turnaround_q8 (bits 0..129), zero fill
	output logic         m_tuser,  // overflow_flag
	output logic         m_tlast   // last_result
);
	cmd_t        cmd;
	status_t     sts;
	logic        in_fire, out_fire;
	logic [5:0]  number;
	logic [7:0]  prio_o;
	logic [15:0] burst_o;
	logic [20:0] wait_o, tat_o;
	logic [28:0] avg_w, avg_t;

	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	pst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast),
		.out_fire(out_fire), .sts(sts), .cmd(cmd), .s_ready(s_tready),
		.m_valid(m_tvalid)
	);

	pst_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .burst_in(s_tdata[15:0]),
		.prio_in(s_tdata[23:16]), .sts(sts), .number(number), .prio_o(prio_o),
		.burst_o(burst_o), .wait_o(wait_o), .tat_o(tat_o), .avg_w(avg_w),
		.avg_t(avg_t), .ovf(m_tuser), .last_o(m_tlast)
	);

	assign m_tdata = {6'd0, avg_t, avg_w, tat_o, wait_o, burst_o, prio_o, number};

	// never accept and emit at once
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("load and emit overlap");
	// turnaround is wait plus burst
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> tat_o == wait_o + 21'(burst_o))
		else $error("turnaround mismatch");
	// after the last result the block returns to loading
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("no return to load");
endmodule
